### hdl/brbps_pkg.sv
// Shared types and constants for the byte ring buffer pattern search unit.
package brbps_pkg;

  localparam int DEPTH       = 256;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_MATCHES = 16;
  localparam int MAX_PATTERN = 4;
  localparam int MATCH_W     = $clog2(MAX_MATCHES + 1);
  localparam int PAT_IW      = $clog2(MAX_PATTERN);

  // result queue holds a whole search worth of results
  localparam int OQ_DEPTH = MAX_MATCHES;
  localparam int OQ_AW    = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int CQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MOVE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_EMPTY  = 3'd1,
    STS_SHORT  = 3'd2,
    STS_RANGE  = 3'd3,
    STS_NOMOVE = 3'd4,
    STS_OVF    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_PATTERN  = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP,
    BK_SCAN,
    BK_FIN,
    BK_OVF
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [SLOT_W-1:0] target;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cap;      // clamped to 1..DEPTH
    logic [31:0]      pattern;
    logic [2:0]       len;      // clamped to 2..MAX_PATTERN
    logic             cap_wr;   // capacity write, empties the buffer
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } oq_stat_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        read_byte;
    logic [SLOT_W-1:0] match_pos;
    logic [CNT_W-1:0]  match_span;
    logic [CNT_W-1:0]  fill_level;
    logic              last;
  } res_t;

endpackage

### hdl/brbps_front.sv
// Front end: accepts request words, decodes the operation, queues commands.
module brbps_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [7:0]                in_data_byte,
  input  logic [brbps_pkg::SLOT_W-1:0] in_head_target,
  output logic                      cmd_valid,
  output brbps_pkg::cmd_t           cmd,
  input  logic                      cmd_pop
);
  import brbps_pkg::*;

  cmd_t       q_r [CQ_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec.op     = op_t'(in_req_type);
    dec.data   = in_data_byte;
    dec.target = in_head_target;
  end

  assign in_stall  = (cnt_r == 2'(CQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/brbps_back.sv
// Back end: ring storage, pointers, and the push/pop/search/move sequencer.
module brbps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  brbps_pkg::cfg_t   cfg,
  input  logic              cmd_valid,
  input  brbps_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  input  brbps_pkg::oq_stat_t oq,
  output logic              res_we,
  output brbps_pkg::res_t   res
);
  import brbps_pkg::*;

  logic [7:0] storage [DEPTH];

  bk_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic [CNT_W-1:0]   pend_span_r, pend_span_nxt;
  logic               have_r, have_nxt;
  logic [MATCH_W-1:0] found_r, found_nxt;
  logic [SLOT_W-1:0]  iss_addr_r, iss_addr_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic               d_valid_r, d_valid_nxt;
  logic [CNT_W-1:0]   d_idx_r, d_idx_nxt;
  logic [7:0]         rd_data_r;
  logic [MAX_PATTERN-1:0][7:0] win_r, win_nxt, win_new;

  logic [SLOT_W-1:0]  rd_addr;
  logic               mem_we;
  logic [CNT_W-1:0]   len9;
  logic               hit_all;
  logic               hit;
  logic               at_start;
  logic               d_last;
  logic               found_last;
  status_t            mv_status;
  logic [CNT_W-1:0]   mv_dec;
  logic [CNT_W-1:0]   tgt9;
  logic [CNT_W-1:0]   head9;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = {1'b0, s} + CNT_W'(1);
    return (inc == cap) ? '0 : inc[SLOT_W-1:0];
  endfunction

  assign len9  = CNT_W'(cfg.len);
  assign tgt9  = {1'b0, cmd.target};
  assign head9 = {1'b0, head_r};

  // sliding window, newest byte at index 0
  assign win_new = {win_r[MAX_PATTERN-2:0], rd_data_r};

  always_comb begin
    logic [2:0] widx;
    hit_all = 1'b1;
    widx    = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      widx = cfg.len - 3'(i) - 3'd1;
      if ((3'(i) < cfg.len) && (win_new[widx[PAT_IW-1:0]] != cfg.pattern[8*i +: 8])) begin
        hit_all = 1'b0;
      end
    end
  end

  assign at_start   = (d_idx_r >= len9 - CNT_W'(1));
  assign hit        = d_valid_r && at_start && hit_all;
  assign d_last     = (d_idx_r == fill_r - CNT_W'(1));
  assign found_last = (found_r == MATCH_W'(MAX_MATCHES - 1));

  // move head: bytes dropped between head and target
  always_comb begin
    mv_status = STS_RANGE;
    mv_dec    = '0;
    if (tgt9 >= cfg.cap) begin
      mv_status = STS_RANGE;
    end else if (head_r == tail_r) begin
      mv_status = STS_NOMOVE;
    end else if (head_r < tail_r) begin
      if ((cmd.target >= head_r) && (cmd.target < tail_r)) begin
        mv_status = STS_OK;
        mv_dec    = tgt9 - head9;
      end
    end else if (cmd.target >= head_r) begin
      mv_status = STS_OK;
      mv_dec    = tgt9 - head9;
    end else if (cmd.target < tail_r) begin
      mv_status = STS_OK;
      mv_dec    = cfg.cap - head9 + tgt9;
    end
  end

  assign rd_addr = (state_r == BK_SCAN) ? iss_addr_r : head_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_POP: begin
              if (!oq.full && (fill_r != '0)) begin
                state_nxt = BK_POP;
              end
            end
            OP_SEARCH: begin
              if (oq.empty && (fill_r >= len9)) begin
                state_nxt = BK_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      BK_POP: state_nxt = BK_IDLE;
      BK_SCAN: begin
        if (d_valid_r) begin
          if (hit && found_last) begin
            state_nxt = BK_OVF;
          end else if (d_last) begin
            state_nxt = BK_FIN;
          end
        end
      end
      BK_FIN:  state_nxt = BK_IDLE;
      BK_OVF:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = 1'b0;
    res_we        = 1'b0;
    res           = '0;
    res.status    = STS_OK;
    res.last      = 1'b1;
    mem_we        = 1'b0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    pend_pos_nxt  = pend_pos_r;
    pend_span_nxt = pend_span_r;
    have_nxt      = have_r;
    found_nxt     = found_r;
    iss_addr_nxt  = iss_addr_r;
    iss_cnt_nxt   = iss_cnt_r;
    pos_nxt       = pos_r;
    win_nxt       = win_r;
    d_valid_nxt   = 1'b0;
    d_idx_nxt     = d_idx_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_PUSH: begin
              if (!oq.full) begin
                cmd_pop  = 1'b1;
                mem_we   = 1'b1;
                res_we   = 1'b1;
                tail_nxt = next_slot(tail_r, cfg.cap);
                if (fill_r >= cfg.cap) begin
                  fill_nxt = cfg.cap;
                  head_nxt = next_slot(head_r, cfg.cap);
                end else begin
                  fill_nxt = fill_r + CNT_W'(1);
                end
              end
            end
            OP_POP: begin
              if (!oq.full) begin
                cmd_pop = 1'b1;
                if (fill_r == '0) begin
                  res_we     = 1'b1;
                  res.status = STS_EMPTY;
                end
              end
            end
            OP_SEARCH: begin
              if (oq.empty) begin
                cmd_pop = 1'b1;
                if (fill_r < len9) begin
                  res_we     = 1'b1;
                  res.status = STS_SHORT;
                end else begin
                  iss_addr_nxt = head_r;
                  iss_cnt_nxt  = '0;
                  pos_nxt      = head_r;
                  have_nxt     = 1'b0;
                  found_nxt    = '0;
                end
              end
            end
            OP_MOVE: begin
              if (!oq.full) begin
                cmd_pop    = 1'b1;
                res_we     = 1'b1;
                res.status = mv_status;
                if (mv_status == STS_OK) begin
                  head_nxt = cmd.target;
                  fill_nxt = fill_r - mv_dec;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_POP: begin
        res_we        = 1'b1;
        res.read_byte = rd_data_r;
        head_nxt      = next_slot(head_r, cfg.cap);
        fill_nxt      = fill_r - CNT_W'(1);
      end
      BK_SCAN: begin
        // read side runs one byte ahead of the compare
        if (iss_cnt_r < fill_r) begin
          d_valid_nxt  = 1'b1;
          d_idx_nxt    = iss_cnt_r;
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
          iss_addr_nxt = next_slot(iss_addr_r, cfg.cap);
        end
        if (d_valid_r) begin
          win_nxt = win_new;
          if (at_start) begin
            pos_nxt = next_slot(pos_r, cfg.cap);
          end
          if (hit) begin
            if (have_r) begin
              res_we         = 1'b1;
              res.match_pos  = pend_pos_r;
              res.match_span = pend_span_r;
              res.last       = 1'b0;
            end
            pend_pos_nxt  = pos_r;
            have_nxt      = 1'b1;
            found_nxt     = found_r + MATCH_W'(1);
            pend_span_nxt = found_last ? '0 : CNT_W'(1);
          end else if (have_r) begin
            pend_span_nxt = pend_span_r + CNT_W'(1);
          end
        end
      end
      BK_FIN: begin
        res_we = 1'b1;
        if (have_r) begin
          pend_span_nxt  = pend_span_r + CNT_W'(1);
          res.match_pos  = pend_pos_r;
          res.match_span = pend_span_r + CNT_W'(1);
        end
      end
      BK_OVF: begin
        res_we        = 1'b1;
        res.status    = STS_OVF;
        res.match_pos = pend_pos_r;
      end
      default: ;
    endcase
    res.fill_level = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      storage[tail_r] <= cmd.data;
    end
    rd_data_r <= storage[rd_addr];
  end

  always_ff @(posedge clk) begin
    iss_addr_r <= iss_addr_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    pos_r      <= pos_nxt;
    d_idx_r    <= d_idx_nxt;
    win_r      <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      pend_pos_r  <= '0;
      pend_span_r <= '0;
      have_r      <= 1'b0;
      found_r     <= '0;
      d_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_pos_r  <= pend_pos_nxt;
      pend_span_r <= pend_span_nxt;
      have_r      <= have_nxt;
      found_r     <= found_nxt;
      d_valid_r   <= d_valid_nxt;
      if (cfg.cap_wr) begin
        head_r <= '0;
        tail_r <= '0;
        fill_r <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

endmodule

### hdl/brbps_outq.sv
// Result queue between the sequencer and the output port.
module brbps_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  brbps_pkg::res_t     wr_data,
  output brbps_pkg::oq_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output brbps_pkg::res_t     out_data
);
  import brbps_pkg::*;

  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             rd_en;

  assign out_valid  = (cnt_r != '0);
  assign out_data   = q_r[rd_ptr_r];
  assign rd_en      = out_valid && !out_stall;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == OQ_CW'(OQ_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + OQ_AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + OQ_AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + OQ_CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/byte_ring_buffer_pattern_search_unit.sv
// Top level of the byte ring buffer pattern search unit.
//
//   channel   handshake               payload
//   in_       in_valid / in_stall     req_type, data_byte, head_target
//   out_      out_valid / out_stall   status, read_byte, match_pos, match_span,
//                                     fill_level, last
//   cfg_      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// Push, move answer when taken; pop answers from POP (one registered read port).
// A search waits for the result queue to drain, then streams the held bytes
// through the read port one per cycle.
// Synchronous active-low reset; storage is not cleared.
// A two-word command queue and a 16-word result queue let each side stall alone.
module byte_ring_buffer_pattern_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_head_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [7:0]  out_match_pos,
  output logic [8:0]  out_match_span,
  output logic [8:0]  out_fill_level,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import brbps_pkg::*;

  logic [CNT_W-1:0] cap_r;
  logic [31:0]      pat_r;
  logic [2:0]       len_r;
  logic             cfg_wr;
  cfg_t             cfg;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  oq_stat_t         oq;
  logic             res_we;
  res_t             res;
  res_t             out_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(DEPTH);
      pat_r <= '0;
      len_r <= 3'd2;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY: cap_r <= cfg_wdata[CNT_W-1:0];
        CFG_PATTERN:  pat_r <= cfg_wdata;
        CFG_PAT_LEN:  len_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cfg.cap = CNT_W'(1);
    end else if (cap_r > CNT_W'(DEPTH)) begin
      cfg.cap = CNT_W'(DEPTH);
    end else begin
      cfg.cap = cap_r;
    end
    if (len_r < 3'd2) begin
      cfg.len = 3'd2;
    end else if (len_r > 3'(MAX_PATTERN)) begin
      cfg.len = 3'(MAX_PATTERN);
    end else begin
      cfg.len = len_r;
    end
    cfg.pattern = pat_r;
    cfg.cap_wr  = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_CAPACITY);
  end

  brbps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .in_head_target (in_head_target),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  brbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq        (oq),
    .res_we    (res_we),
    .res       (res)
  );

  brbps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_we),
    .wr_data   (res),
    .stat      (oq),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status     = out_data.status;
  assign out_read_byte  = out_data.read_byte;
  assign out_match_pos  = out_data.match_pos;
  assign out_match_span = out_data.match_span;
  assign out_fill_level = out_data.fill_level;
  assign out_last       = out_data.last;

endmodule

### tb/sv/byte_ring_buffer_pattern_search_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the byte ring buffer pattern search unit.
module byte_ring_buffer_pattern_search_unit_tb;
  import brbps_pkg::*;

  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         RUN_LIMIT    = 1000000;
  localparam int         DRAIN_CYCLES = 300;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type    = '0;
  logic [7:0]  in_data_byte   = '0;
  logic [7:0]  in_head_target = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_read_byte;
  logic [7:0]  out_match_pos;
  logic [8:0]  out_match_span;
  logic [8:0]  out_fill_level;
  logic        out_last;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index      = '0;
  logic [31:0] cfg_wdata      = '0;

  byte_ring_buffer_pattern_search_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .in_head_target (in_head_target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_match_pos  (out_match_pos),
    .out_match_span (out_match_span),
    .out_fill_level (out_fill_level),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  // buffer state as the block should hold it
  logic [7:0]        ring_mem [DEPTH];
  logic [SLOT_W-1:0] head_slot    = '0;
  logic [SLOT_W-1:0] tail_slot    = '0;
  logic [CNT_W-1:0]  fill_cnt     = '0;
  logic [SLOT_W-1:0] match_pos_q  = '0;
  logic [CNT_W-1:0]  match_span_q = '0;
  logic [8:0]        cap_reg      = 9'd256;
  logic [31:0]       pat_reg      = '0;
  logic [2:0]        plen_reg     = 3'd2;

  cmd_t ring_cmd_q [$];
  res_t res_expect_q [$];
  cmd_t cur_cmd;
  bit   in_flight  = 1'b0;
  int   send_gap   = 0;
  int   stall_left = 0;
  bit   quiet_in   = 1'b0;
  bit   quiet_out  = 1'b0;
  int   pat_seq_idx = 0;

  int          mismatch_cnt = 0;
  int          n_requests   = 0;
  int          n_words      = 0;
  int          n_matches    = 0;
  int          n_overflows  = 0;
  int          n_settings   = 1;
  int unsigned cycle_cnt    = 0;

  function automatic int ring_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int pat_len_eff();
    if (plen_reg < 2) return 2;
    if (plen_reg > MAX_PATTERN) return MAX_PATTERN;
    return int'(plen_reg);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_after(int s, int k);
    return SLOT_W'((s + k) % ring_cap());
  endfunction

  function automatic int idle_draw(bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic post_result(status_t st, logic [7:0] rb, int pos, int span, bit lst);
    res_t r;
    r.status     = st;
    r.read_byte  = rb;
    r.match_pos  = SLOT_W'(pos);
    r.match_span = CNT_W'(span);
    r.fill_level = fill_cnt;
    r.last       = lst;
    res_expect_q.push_back(r);
  endtask

  // apply one accepted request and queue the result words it should produce
  task automatic ring_model_step(cmd_t c);
    int  cap, lenv, fillv, h, t, p, s, k, found;
    bit  hit, have, stopped;
    logic [7:0] v;
    status_t st;
    cap = ring_cap();
    n_requests++;
    case (c.op)
      OP_PUSH: begin
        ring_mem[tail_slot] = c.data;
        tail_slot = slot_after(tail_slot, 1);
        if (fill_cnt >= cap) begin
          fill_cnt  = CNT_W'(cap);
          head_slot = slot_after(head_slot, 1);
        end else begin
          fill_cnt++;
        end
        post_result(STS_OK, 8'h00, 0, 0, 1'b1);
      end
      OP_POP: begin
        if (fill_cnt == 0) begin
          post_result(STS_EMPTY, 8'h00, 0, 0, 1'b1);
        end else begin
          v = ring_mem[head_slot];
          ring_mem[head_slot] = 8'h00;
          head_slot = slot_after(head_slot, 1);
          fill_cnt--;
          post_result(STS_OK, v, 0, 0, 1'b1);
        end
      end
      OP_SEARCH: begin
        lenv  = pat_len_eff();
        fillv = fill_cnt;
        if (fillv < lenv) begin
          post_result(STS_SHORT, 8'h00, 0, 0, 1'b1);
        end else begin
          have    = 1'b0;
          stopped = 1'b0;
          found   = 0;
          for (s = 0; s < fillv - lenv + 1 && !stopped; s++) begin
            p   = (head_slot + s) % cap;
            hit = 1'b1;
            for (k = 0; k < lenv; k++)
              if (ring_mem[(p + k) % cap] != pat_reg[8*k +: 8]) hit = 1'b0;
            if (hit) begin
              // previous match is closed out once the next one is seen
              if (have) post_result(STS_OK, 8'h00, match_pos_q, match_span_q, 1'b0);
              match_pos_q  = SLOT_W'(p);
              match_span_q = '0;
              have = 1'b1;
              found++;
              n_matches++;
              if (found >= MAX_MATCHES) begin
                post_result(STS_OVF, 8'h00, p, 0, 1'b1);
                n_overflows++;
                stopped = 1'b1;
              end
            end
            if (have && !stopped) match_span_q++;
          end
          if (!stopped) begin
            if (have) begin
              match_span_q++;
              post_result(STS_OK, 8'h00, match_pos_q, match_span_q, 1'b1);
            end else begin
              post_result(STS_OK, 8'h00, 0, 0, 1'b1);
            end
          end
        end
      end
      default: begin
        h = head_slot;
        t = tail_slot;
        p = c.target;
        if (p >= cap) begin
          st = STS_RANGE;
        end else if (h == t) begin
          st = STS_NOMOVE;
        end else if (h < t) begin
          st = (p >= h && p < t) ? STS_OK : STS_RANGE;
          if (st == STS_OK) fill_cnt = CNT_W'(fill_cnt - (p - h));
        end else if (p >= h) begin
          st = STS_OK;
          fill_cnt = CNT_W'(fill_cnt - (p - h));
        end else if (p < t) begin
          // wrapped held region, target in the part below the tail
          st = STS_OK;
          fill_cnt = CNT_W'(fill_cnt - ((cap - h) + p));
        end else begin
          st = STS_RANGE;
        end
        if (st == STS_OK) head_slot = SLOT_W'(p);
        post_result(st, 8'h00, 0, 0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_flight = 1'b0;
      send_gap  = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ring_model_step(cur_cmd);
        in_flight = 1'b0;
        send_gap  = idle_draw(quiet_in);
      end
      if (!in_flight) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ring_cmd_q.size() != 0) begin
          cur_cmd = ring_cmd_q.pop_front();
          in_req_type    <= cur_cmd.op;
          in_data_byte   <= cur_cmd.data;
          in_head_target <= cur_cmd.target;
          in_flight = 1'b1;
        end
      end
      in_valid <= in_flight;
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (res_expect_q.size() == 0) begin
          $error("result word with nothing pending, status %0d", out_status);
          mismatch_cnt++;
        end else begin
          want = res_expect_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("read_byte", want.read_byte, out_read_byte);
          check_field("match_pos", want.match_pos, out_match_pos);
          check_field("match_span", want.match_span, out_match_span);
          check_field("fill_level", want.fill_level, out_fill_level);
          check_field("last", want.last, out_last);
        end
        stall_left = idle_draw(quiet_out);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_cmd(op_t op, logic [7:0] d, logic [7:0] tgt);
    cmd_t c;
    c.op     = op;
    c.data   = d;
    c.target = tgt;
    ring_cmd_q.push_back(c);
  endtask

  task automatic wait_idle();
    while (ring_cmd_q.size() != 0 || in_flight || res_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAPACITY: begin
        cap_reg   = val[8:0];
        head_slot = '0;
        tail_slot = '0;
        fill_cnt  = '0;
      end
      CFG_PATTERN: pat_reg  = val;
      CFG_PAT_LEN: plen_reg = val[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // random request; data leans on pattern bytes so searches find matches
  task automatic gen_item(int push_pct);
    cmd_t c;
    int   lenv, roll, k;
    lenv     = pat_len_eff();
    roll     = $urandom_range(0, 99);
    c.data   = 8'($urandom_range(0, 255));
    c.target = SLOT_W'($urandom_range(0, 255));
    if (roll < push_pct) begin
      c.op = OP_PUSH;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        k = pat_seq_idx % lenv;
        c.data = pat_reg[8*k +: 8];
        pat_seq_idx = (k + 1) % lenv;
      end else if (roll < 85) begin
        k = $urandom_range(0, lenv - 1);
        c.data = pat_reg[8*k +: 8];
      end
    end else begin
      c.op = op_t'($urandom_range(1, 3));
      if (c.op == OP_MOVE && fill_cnt != 0 && $urandom_range(0, 9) < 6)
        c.target = SLOT_W'((head_slot + $urandom_range(0, fill_cnt - 1)) % ring_cap());
    end
    ring_cmd_q.push_back(c);
  endtask

  task automatic run_phase(logic [8:0] cap, logic [31:0] pat, logic [2:0] len,
                           int n_items, int push_pct, bit quiet);
    int left, batch;
    wait_idle();
    quiet_in  = quiet;
    quiet_out = quiet;
    cfg_write(CFG_CAPACITY, 32'(cap));
    cfg_write(CFG_PATTERN, pat);
    cfg_write(CFG_PAT_LEN, 32'(len));
    n_settings++;
    left = n_items;
    while (left > 0) begin
      batch = $urandom_range(1, 8);
      if (batch > left) batch = left;
      repeat (batch) gen_item(push_pct);
      left -= batch;
      while (ring_cmd_q.size() != 0) @(negedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // write to the unused index must leave the reset settings alone
    cfg_write(CFG_UNUSED, $urandom());

    // directed: reset settings, capacity 256, pattern 00 00
    queue_cmd(OP_POP,    8'h00, 8'h00);  // empty
    queue_cmd(OP_SEARCH, 8'h00, 8'h00);  // too few bytes
    queue_cmd(OP_MOVE,   8'h00, 8'h00);  // head equals tail
    queue_cmd(OP_MOVE,   8'hFF, 8'hFF);
    queue_cmd(OP_PUSH,   8'h00, 8'h00);
    queue_cmd(OP_PUSH,   8'hFF, 8'h00);
    queue_cmd(OP_PUSH,   8'h00, 8'h00);
    queue_cmd(OP_PUSH,   8'h00, 8'h00);
    queue_cmd(OP_SEARCH, 8'hFF, 8'hFF);
    queue_cmd(OP_MOVE,   8'h00, 8'hFF);  // outside held region
    queue_cmd(OP_MOVE,   8'h00, 8'h01);
    queue_cmd(OP_POP,    8'h00, 8'h00);
    queue_cmd(OP_SEARCH, 8'h00, 8'h00);
    queue_cmd(OP_POP,    8'h00, 8'h00);
    queue_cmd(OP_POP,    8'h00, 8'h00);
    queue_cmd(OP_POP,    8'h00, 8'h00);
    queue_cmd(OP_PUSH,   8'h12, 8'h00);
    queue_cmd(OP_PUSH,   8'h34, 8'h00);
    queue_cmd(OP_SEARCH, 8'h00, 8'h00);  // no match
    queue_cmd(OP_MOVE,   8'h00, 8'h07);

    run_phase(9'd5,   $urandom(),    3'd2, 20, 50, 1'b0);
    run_phase(9'd0,   $urandom(),    3'd0, 12, 50, 1'b0);
    run_phase(9'd511, 32'h0,         3'd1, 40, 85, 1'b0);
    run_phase(9'd16,  32'hFFFF_FFFF, 3'd7, 20, 55, 1'b0);
    run_phase(9'd300, $urandom(),    3'd3, 20, 70, 1'b0);
    run_phase(9'd8,   $urandom(),    3'd4, 20, 50, 1'b0);
    run_phase(9'd64,  $urandom(),    3'd4, 20, 60, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests under %0d buffer settings, checked %0d result words.",
             n_requests, n_settings, n_words);
    $display("Searches found %0d matches and hit the match limit %0d times.",
             n_matches, n_overflows);
    if (mismatch_cnt == 0 && res_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/brbps_pkg.sv
hdl/brbps_front.sv
hdl/brbps_back.sv
hdl/brbps_outq.sv
hdl/byte_ring_buffer_pattern_search_unit.sv
tb/sv/byte_ring_buffer_pattern_search_unit_tb.sv
